@@ rtl/button_debounce_array_top_macros.svh @@
// Assertion helpers shared by the debounce array files.
`ifndef BUTTON_DEBOUNCE_ARRAY_TOP_MACROS_SVH
`define BUTTON_DEBOUNCE_ARRAY_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BDA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("debounce array check failed");

// Consequent must hold in the cycle after the antecedent.
`define BDA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("debounce array check failed");

`endif

@@ rtl/bda_pkg.sv @@
package bda_pkg;

  localparam int SampleBits = 8;
  localparam int CountWidth = 16;
  localparam int PhaseWidth = 3;

  typedef logic [PhaseWidth-1:0] phase_t;
  typedef logic [CountWidth-1:0] count_t;

  localparam phase_t PH_IDLE    = 3'd0;
  localparam phase_t PH_PDEB    = 3'd1;
  localparam phase_t PH_PRESSED = 3'd2;
  localparam phase_t PH_HELD    = 3'd3;
  localparam phase_t PH_RDEB    = 3'd4;

  localparam count_t ThresholdReset = 16'd50;

  // Phase of one button after the update, as one flag per reported phase.
  typedef struct packed {
    logic pressed;
    logic held;
    logic press_deb;
    logic release_deb;
  } flags_t;

endpackage

@@ rtl/bda_cell.sv @@
`include "button_debounce_array_top_macros.svh"

module bda_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic             level,
  input  bda_pkg::count_t  threshold,
  output bda_pkg::flags_t  flags_next
);

  bda_pkg::phase_t phase;
  bda_pkg::phase_t phase_next;
  bda_pkg::count_t count;
  bda_pkg::count_t count_next;
  bda_pkg::count_t bumped;
  logic            confirm;
  logic            in_pressed;
  logic            rest_phase;

  // Saturate the stable-tick count at all ones.
  assign bumped  = (count == '1) ? count : count + bda_pkg::count_t'(1);
  assign confirm = bumped > threshold;

  always_comb begin
    phase_next = phase;
    count_next = count;
    unique case (phase)
      bda_pkg::PH_PDEB: begin
        if (level) begin
          count_next = bumped;
          if (confirm) begin
            count_next = '0;
            phase_next = bda_pkg::PH_PRESSED;
          end
        end else begin
          count_next = '0;
          phase_next = bda_pkg::PH_IDLE;
        end
      end
      bda_pkg::PH_PRESSED: begin
        count_next = '0;
        phase_next = bda_pkg::PH_HELD;
      end
      bda_pkg::PH_HELD: begin
        if (!level) begin
          count_next = '0;
          phase_next = bda_pkg::PH_RDEB;
        end
      end
      bda_pkg::PH_RDEB: begin
        if (level) begin
          count_next = '0;
          phase_next = bda_pkg::PH_HELD;
        end else begin
          count_next = bumped;
          if (confirm) begin
            count_next = '0;
            phase_next = bda_pkg::PH_IDLE;
          end
        end
      end
      default: begin
        // Idle, and any stray code treated as idle
        phase_next = bda_pkg::PH_IDLE;
        if (level) begin
          count_next = '0;
          phase_next = bda_pkg::PH_PDEB;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= bda_pkg::PH_IDLE;
      count <= '0;
    end else if (advance) begin
      phase <= phase_next;
      count <= count_next;
    end
  end

  assign flags_next.pressed     = phase_next == bda_pkg::PH_PRESSED;
  assign flags_next.held        = phase_next == bda_pkg::PH_HELD;
  assign flags_next.press_deb   = phase_next == bda_pkg::PH_PDEB;
  assign flags_next.release_deb = phase_next == bda_pkg::PH_RDEB;

  assign in_pressed = phase == bda_pkg::PH_PRESSED;
  assign rest_phase = (phase == bda_pkg::PH_IDLE) || in_pressed ||
                      (phase == bda_pkg::PH_HELD);

  `BDA_ASSERT_NEXT(a_pressed_one_tick, advance && in_pressed, phase == bda_pkg::PH_HELD)
  `BDA_ASSERT_NEXT(a_hold_when_idle, !advance, $stable(phase) && $stable(count))
  `BDA_ASSERT_NOW(a_count_clear, rest_phase, count == '0)

endmodule

@@ rtl/button_debounce_array_top.sv @@
// Debounced button array: each accepted word on the input channel is one
// sample tick of raw switch levels (bit i is button i, 1 = pressed); each
// button runs its own idle / press debounce / pressed / held / release
// debounce machine with a saturating 16-bit stable-tick counter, and a change
// is confirmed once that count exceeds debounce_threshold (reset 50). Every
// tick yields exactly one result word with the phase masks after the update;
// pressed_pulse_mask is set for one tick only. The block takes one word per
// cycle while out_ready stays high; a result word is presented once its sample
// leaves the sample register, which feeds the per-button phase logic whose
// outputs load the result register when the word advances (held off while an
// untaken result waits). The threshold is written through the cfg channel,
// which is always ready, and must only be changed while no tick is in flight.
// Buttons beyond the eight sample bits never leave idle and are not built.
`include "button_debounce_array_top_macros.svh"

module button_debounce_array_top #(
  parameter int BUTTON_COUNT = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [15:0] debounce_threshold,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] switch_sample,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] pressed_pulse_mask,
  output logic [7:0] held_mask,
  output logic [7:0] press_debounce_mask,
  output logic [7:0] release_debounce_mask
);

  localparam int Lanes = (BUTTON_COUNT < bda_pkg::SampleBits) ?
                         BUTTON_COUNT : bda_pkg::SampleBits;

  bda_pkg::count_t                  threshold;
  logic                             stage_valid;
  logic [bda_pkg::SampleBits-1:0]   sample;
  logic                             advance;
  logic [bda_pkg::SampleBits-1:0]   pressed_next;
  logic [bda_pkg::SampleBits-1:0]   held_next;
  logic [bda_pkg::SampleBits-1:0]   pdeb_next;
  logic [bda_pkg::SampleBits-1:0]   rdeb_next;
  logic                             masks_overlap;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= bda_pkg::ThresholdReset;
    end else if (cfg_valid) begin
      threshold <= debounce_threshold;
    end
  end

  // Sample register; refills when empty or whenever its word moves on to the result stage.
  assign advance  = stage_valid && (!out_valid || out_ready);
  assign in_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sample <= switch_sample;
    end
  end

  for (genvar g = 0; g < bda_pkg::SampleBits; g++) begin : g_lane
    if (g < Lanes) begin : g_cell
      bda_pkg::flags_t flags;

      bda_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .advance    (advance),
        .level      (sample[g]),
        .threshold  (threshold),
        .flags_next (flags)
      );

      assign pressed_next[g] = flags.pressed;
      assign held_next[g]    = flags.held;
      assign pdeb_next[g]    = flags.press_deb;
      assign rdeb_next[g]    = flags.release_deb;
    end else begin : g_none
      assign pressed_next[g] = 1'b0;
      assign held_next[g]    = 1'b0;
      assign pdeb_next[g]    = 1'b0;
      assign rdeb_next[g]    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pressed_pulse_mask    <= pressed_next;
      held_mask             <= held_next;
      press_debounce_mask   <= pdeb_next;
      release_debounce_mask <= rdeb_next;
    end
  end

  assign masks_overlap =
    ((pressed_pulse_mask & (held_mask | press_debounce_mask | release_debounce_mask)) != '0) ||
    ((held_mask & (press_debounce_mask | release_debounce_mask)) != '0) ||
    ((press_debounce_mask & release_debounce_mask) != '0);

  `BDA_ASSERT_NOW(a_masks_disjoint, out_valid, !masks_overlap)
  `BDA_ASSERT_NEXT(a_stage_holds, !in_ready, stage_valid && $stable(sample))
  `BDA_ASSERT_NEXT(a_out_holds, out_valid && !out_ready, out_valid && $stable(held_mask))

endmodule
